// ===== rtl/ivt_pkg.sv =====
// shared types and constants for the interval timer with vectored interrupt
// no dependencies; imported by every module of the block
package ivt_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_ACK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ACK_MASKED   = 2'd0,
        ACK_SPURIOUS = 2'd1,
        ACK_VECTORED = 2'd2,
        ACK_AUTOVEC  = 2'd3
    } t_ack;

    // register selects of the byte-wide register file
    localparam logic [3:0] SEL_CONTROL = 4'd0;
    localparam logic [3:0] SEL_VECTOR  = 4'd1;
    localparam logic [3:0] SEL_NULL    = 4'd2;
    localparam logic [3:0] SEL_PRE_H   = 4'd3;
    localparam logic [3:0] SEL_PRE_M   = 4'd4;
    localparam logic [3:0] SEL_PRE_L   = 4'd5;
    localparam logic [3:0] SEL_CNT_H   = 4'd6;
    localparam logic [3:0] SEL_CNT_M   = 4'd7;
    localparam logic [3:0] SEL_CNT_L   = 4'd8;
    localparam logic [3:0] SEL_STATUS  = 4'd9;

    localparam int unsigned CNT_W     = 24;
    localparam logic [CNT_W-1:0] TICK_STEP = 24'd250;

    // control register mode field values that raise a request
    localparam logic [2:0] MODE_VECTORED = 3'd5;
    localparam logic [2:0] MODE_AUTOVEC  = 3'd7;

    // configuration register map
    localparam logic       CFG_IRQ_LEVEL   = 1'b0;
    localparam logic [2:0] IRQ_LEVEL_RESET = 3'd5;
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    typedef struct packed {
        t_op        op;
        logic [3:0] reg_sel;
        logic [7:0] write_data;
        logic [2:0] ack_mask;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        t_ack       ack_status;
        logic [7:0] ack_vector;
        logic       irq_pending;
    } t_result;

endpackage

// ===== rtl/interval_timer_with_vectored_irq.sv =====
// top level of the interval timer with vectored interrupt
// input register, result register and apb port around ivt_core; depends on ivt_pkg
//
// usage: each input transfer carries one operation (register read, register
// write, tick or interrupt acknowledge) on i_op, i_reg_sel, i_write_data and
// i_ack_mask; each one gives exactly one result transfer with o_read_data,
// o_ack_status, o_ack_vector and o_irq_pending, in order.
// flow: an accepted transfer lands in the input register, is executed
// against the timer state and is captured in the result register once that
// register is free or being drained.
// throughput: one transfer per cycle while i_out_ready is high, set by the
// single execute step between the input and result registers; the timer
// state updates in that step so the following transfer sees it at once.
// stall: when the receiver holds i_out_ready low the result waits in the
// result register and one more transfer waits in the input register; only
// then does o_in_ready drop.
// reset: synchronous, active low; clears both pipeline registers, loads the timer
// registers with zero, sets irq_level to 5. the user must see that irq_level is
// written over apb at address 0 only while the block is idle; nothing enforces it.
module interval_timer_with_vectored_irq
    import ivt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_op,
    input  logic [3:0]        i_reg_sel,
    input  logic [7:0]        i_write_data,
    input  logic [2:0]        i_ack_mask,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_read_data,
    output logic [1:0]        o_ack_status,
    output logic [7:0]        o_ack_vector,
    output logic              o_irq_pending,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result exec_result;
    logic    fire;
    logic [2:0] irq_level;

    // execute when the result register is free or being drained
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.op         <= t_op'(i_op);
            r_item.reg_sel    <= i_reg_sel;
            r_item.write_data <= i_write_data;
            r_item.ack_mask   <= i_ack_mask;
        end
        if (fire) begin
            r_result <= exec_result;
        end
    end

    ivt_apb u_apb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_irq_level (irq_level)
    );

    ivt_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_item),
        .i_irq_level (irq_level),
        .o_result    (exec_result)
    );

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_result.read_data;
    assign o_ack_status  = r_result.ack_status;
    assign o_ack_vector  = r_result.ack_vector;
    assign o_irq_pending = r_result.irq_pending;

endmodule

// ===== rtl/ivt_apb.sv =====
// apb configuration port holding the interrupt priority level
// depends on ivt_pkg
module ivt_apb
    import ivt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [2:0]        o_irq_level
);

    logic [2:0] r_irq_level;
    logic [2:0] n_irq_level;
    logic       sel_level;

    // word aligned decode, byte lanes ignored
    assign sel_level = (paddr[2] == CFG_IRQ_LEVEL);
    assign pready    = 1'b1;

    always_comb begin
        n_irq_level = r_irq_level;
        if (psel && penable && pwrite && pready && sel_level) begin
            n_irq_level = pwdata[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_level <= IRQ_LEVEL_RESET;
        end else begin
            r_irq_level <= n_irq_level;
        end
    end

    assign prdata      = sel_level ? {{(APB_DW-3){1'b0}}, r_irq_level} : '0;
    assign o_irq_level = r_irq_level;

endmodule

// ===== rtl/ivt_core.sv =====
// timer register file, down counter and interrupt acknowledge logic
// executes one transfer per cycle when i_fire is high; depends on ivt_pkg
module ivt_core
    import ivt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  logic [2:0] i_irq_level,
    output t_result o_result
);

    logic [7:0]       r_control, n_control;
    logic [7:0]       r_vector,  n_vector;
    logic [7:0]       r_null,    n_null;
    logic [CNT_W-1:0] r_preload, n_preload;
    logic [CNT_W-1:0] r_count,   n_count;
    logic [7:0]       r_status,  n_status;
    logic             r_needs_load, n_needs_load;
    logic             r_pending,    n_pending;

    logic [2:0]       mode;
    logic             mode_irq;
    logic [CNT_W-1:0] cnt_base;
    logic [CNT_W-1:0] cnt_next;
    logic [7:0]       rd_byte;

    assign mode     = r_control[7:5];
    assign mode_irq = (mode == MODE_VECTORED) || (mode == MODE_AUTOVEC);
    assign cnt_base = r_needs_load ? r_preload : r_count;
    // saturating subtract of one tick step
    assign cnt_next = (cnt_base < TICK_STEP) ? '0 : (cnt_base - TICK_STEP);

    always_comb begin
        case (i_item.reg_sel)
            SEL_CONTROL: rd_byte = r_control;
            SEL_VECTOR:  rd_byte = r_vector;
            SEL_NULL:    rd_byte = r_null;
            SEL_PRE_H:   rd_byte = r_preload[23:16];
            SEL_PRE_M:   rd_byte = r_preload[15:8];
            SEL_PRE_L:   rd_byte = r_preload[7:0];
            SEL_CNT_H:   rd_byte = r_count[23:16];
            SEL_CNT_M:   rd_byte = r_count[15:8];
            SEL_CNT_L:   rd_byte = r_count[7:0];
            SEL_STATUS:  rd_byte = r_status;
            default:     rd_byte = 8'd0;
        endcase
    end

    always_comb begin
        n_control    = r_control;
        n_vector     = r_vector;
        n_null       = r_null;
        n_preload    = r_preload;
        n_count      = r_count;
        n_status     = r_status;
        n_needs_load = r_needs_load;
        n_pending    = r_pending;

        o_result             = '0;
        o_result.ack_status  = ACK_MASKED;

        case (i_item.op)
            OP_READ: begin
                o_result.read_data = rd_byte;
            end
            OP_WRITE: begin
                // counter bytes are read-only
                case (i_item.reg_sel)
                    SEL_CONTROL: n_control = i_item.write_data;
                    SEL_VECTOR:  n_vector  = i_item.write_data;
                    SEL_NULL:    n_null    = i_item.write_data;
                    SEL_PRE_H:   n_preload[23:16] = i_item.write_data;
                    SEL_PRE_M:   n_preload[15:8]  = i_item.write_data;
                    SEL_PRE_L:   n_preload[7:0]   = i_item.write_data;
                    SEL_STATUS:  n_status  = i_item.write_data;
                    default:     n_status  = r_status;
                endcase
            end
            OP_TICK: begin
                if (r_control[0]) begin
                    n_count      = cnt_next;
                    n_needs_load = (cnt_next == '0);
                    if (cnt_next == '0) begin
                        n_control[0] = 1'b0;
                        n_status[0]  = 1'b1;
                        if (mode_irq) begin
                            n_pending = 1'b1;
                        end
                    end
                end
            end
            OP_ACK: begin
                if (i_item.ack_mask > i_irq_level) begin
                    o_result.ack_status = ACK_MASKED;
                end else if (!r_pending) begin
                    o_result.ack_status = ACK_SPURIOUS;
                end else if (mode == MODE_VECTORED) begin
                    n_pending           = 1'b0;
                    o_result.ack_status = ACK_VECTORED;
                    o_result.ack_vector = r_vector;
                end else if (mode == MODE_AUTOVEC) begin
                    n_pending           = 1'b0;
                    o_result.ack_status = ACK_AUTOVEC;
                end else begin
                    o_result.ack_status = ACK_SPURIOUS;
                end
            end
            default: begin
                o_result.ack_status = ACK_MASKED;
            end
        endcase

        o_result.irq_pending = n_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control    <= '0;
            r_vector     <= '0;
            r_null       <= '0;
            r_preload    <= '0;
            r_count      <= '0;
            r_status     <= '0;
            r_needs_load <= 1'b1;
            r_pending    <= 1'b0;
        end else if (i_fire) begin
            r_control    <= n_control;
            r_vector     <= n_vector;
            r_null       <= n_null;
            r_preload    <= n_preload;
            r_count      <= n_count;
            r_status     <= n_status;
            r_needs_load <= n_needs_load;
            r_pending    <= n_pending;
        end
    end

endmodule
